>>> hdl/prefix_suffix_neighbour_lookup_macros.svh
// Assertion macros for the prefix/suffix neighbor lookup block
`ifndef PREFIX_SUFFIX_NEIGHBOUR_LOOKUP_MACROS_SVH
`define PREFIX_SUFFIX_NEIGHBOUR_LOOKUP_MACROS_SVH

// same-cycle implication, checked out of reset
`define PSNL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psnl: implication check failed");

// next-cycle implication, checked out of reset
`define PSNL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psnl: next-cycle check failed");

`endif

>>> hdl/psnl_pkg.sv
// Shared types and constants for the prefix/suffix neighbor lookup block
package psnl_pkg;

  localparam int REQ_W   = 2;
  localparam int KEY_W   = 12;
  localparam int FIRST_W = 12;
  localparam int CNT_W   = 13;
  localparam int SIDX_W  = 12;
  localparam int STAT_W  = 2;

  localparam int DEF_PREFIX_COUNT = 4096;
  localparam int DEF_SUFFIX_DEPTH = 4096;
  localparam int DEF_SUFFIX_WIDTH = 32;
  localparam int DEF_CLASS_WIDTH  = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_PREFIX = 2'd0,
    REQ_SUFFIX = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_EXACT   = 2'd0,
    ST_INEXACT = 2'd1,
    ST_OOB     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_OOB    = 2'd0,
    MODE_EMPTY  = 2'd1,
    MODE_SEARCH = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    B_KEEP  = 2'd0,
    B_ZERO  = 2'd1,
    B_FIRST = 2'd2,
    B_LAST  = 2'd3
  } base_e;

  typedef enum logic [2:0] {
    LH_KEEP     = 3'd0,
    LH_ZERO     = 3'd1,
    LH_ZERO_ONE = 3'd2,
    LH_LAST     = 3'd3,
    LH_FULL     = 3'd4
  } lohi_e;

  typedef enum logic [2:0] {
    OFF_ZERO = 3'd0,
    OFF_LAST = 3'd1,
    OFF_MID  = 3'd2,
    OFF_LO   = 3'd3,
    OFF_HI   = 3'd4
  } off_e;

  typedef struct packed {
    logic [FIRST_W-1:0] first;
    logic [CNT_W-1:0]   count;
    logic               edge_flag;
  } pt_ent_t;

  typedef struct packed {
    logic   pt_wr;
    logic   st_wr;
    logic   clr_wr;
    logic   pt_rd_key;
    logic   pt_rd_tmp;
    logic   tmp_load_key;
    logic   tmp_inc;
    logic   tmp_dec;
    logic   lat_req;
    logic   set_mode;
    mode_e  mode;
    logic   n_load;
    base_e  base;
    lohi_e  lohi;
    logic   lo_mid;
    logic   hi_mid;
    logic   lp_load;
    logic   up_load;
    logic   st_rd;
    off_e   off;
    logic   lat_lower;
    logic   lat_upper;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic ent_edge;
    logic ent_first_zero;
    logic ent_count_zero;
    logic tmp_min;
    logic tmp_max;
    logic s_lt;
    logic s_gt;
    logic s_eq;
    logic span_gt1;
    logic out_busy;
  } dp_sts_t;

endpackage

>>> hdl/prefix_suffix_neighbour_lookup.sv
// A write is taken in the idle state. A lookup reads its prefix entry, then: an edge prefix walks
// prefix by prefix, up if its first index is zero else down; an empty prefix walks down, then up;
// a search compares with the first suffix, then the last, else narrows by halving steps.
// Throughput: one transaction in flight; the next is taken in the cycle after the result loads.
// Reset: asynchronous, active low; then a sweep zeroes the prefix table with in_ready_o low.
// Depths are powers of two; the suffix store is undefined until written.
module prefix_suffix_neighbour_lookup #(
  parameter int PREFIX_COUNT = psnl_pkg::DEF_PREFIX_COUNT,
  parameter int SUFFIX_DEPTH = psnl_pkg::DEF_SUFFIX_DEPTH,
  parameter int SUFFIX_WIDTH = psnl_pkg::DEF_SUFFIX_WIDTH,
  parameter int CLASS_WIDTH  = psnl_pkg::DEF_CLASS_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [psnl_pkg::REQ_W-1:0]     req_type_i,
  input  logic [psnl_pkg::KEY_W-1:0]     prefix_key_i,
  input  logic [psnl_pkg::FIRST_W-1:0]   entry_first_i,
  input  logic [psnl_pkg::CNT_W-1:0]     entry_count_i,
  input  logic                           entry_edge_i,
  input  logic [psnl_pkg::SIDX_W-1:0]    suffix_index_i,
  input  logic [SUFFIX_WIDTH-1:0]        suffix_value_i,
  input  logic [CLASS_WIDTH-1:0]         class_value_i,
  input  logic [SUFFIX_WIDTH-1:0]        search_suffix_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [psnl_pkg::STAT_W-1:0]    status_o,
  output logic [psnl_pkg::KEY_W-1:0]     below_prefix_o,
  output logic [SUFFIX_WIDTH-1:0]        below_suffix_o,
  output logic [CLASS_WIDTH-1:0]         below_class_o,
  output logic [psnl_pkg::KEY_W-1:0]     above_prefix_o,
  output logic [SUFFIX_WIDTH-1:0]        above_suffix_o,
  output logic [CLASS_WIDTH-1:0]         above_class_o
);
  import psnl_pkg::*;
  `include "prefix_suffix_neighbour_lookup_macros.svh"

  dp_cmd_t cmd;
  dp_sts_t sts;

  psnl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psnl_dp #(
    .PREFIX_COUNT (PREFIX_COUNT),
    .SUFFIX_DEPTH (SUFFIX_DEPTH),
    .SUFFIX_WIDTH (SUFFIX_WIDTH),
    .CLASS_WIDTH  (CLASS_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .prefix_key_i    (prefix_key_i),
    .entry_first_i   (entry_first_i),
    .entry_count_i   (entry_count_i),
    .entry_edge_i    (entry_edge_i),
    .suffix_index_i  (suffix_index_i),
    .suffix_value_i  (suffix_value_i),
    .class_value_i   (class_value_i),
    .search_suffix_i (search_suffix_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .below_prefix_o  (below_prefix_o),
    .below_suffix_o  (below_suffix_o),
    .below_class_o   (below_class_o),
    .above_prefix_o  (above_prefix_o),
    .above_suffix_o  (above_suffix_o),
    .above_class_o   (above_class_o)
  );

  // no transaction is taken before the clear sweep is through
  `PSNL_ASSERT_IMP(a_ready_after_clear, in_ready_o, sts.clr_done)
  // a new result never overwrites one still waiting
  `PSNL_ASSERT_IMP(a_no_overwrite, cmd.out_load, !(out_valid_o && !out_ready_i))
  // a taken result with nothing new behind it drops valid
  `PSNL_ASSERT_NXT(a_valid_drops, out_valid_o && out_ready_i && !cmd.out_load, !out_valid_o)

endmodule

>>> hdl/psnl_ctrl.sv
// Controller state machine: clear sweep, writes, prefix walks and binary search
module psnl_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [psnl_pkg::REQ_W-1:0]    req_type_i,
  input  psnl_pkg::dp_sts_t             sts_i,
  output psnl_pkg::dp_cmd_t             cmd_o
);
  import psnl_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_CLEAR = 16'h0002,
    S_K_RD  = 16'h0004,
    S_K_CHK = 16'h0008,
    S_W_RD  = 16'h0010,
    S_W_CHK = 16'h0020,
    S_RD0   = 16'h0040,
    S_CK0   = 16'h0080,
    S_RDN   = 16'h0100,
    S_CKN   = 16'h0200,
    S_L_CK  = 16'h0400,
    S_L_CMP = 16'h0800,
    S_F_RLO = 16'h1000,
    S_F_RHI = 16'h2000,
    S_F_HI  = 16'h4000,
    S_OUT   = 16'h8000
  } state_e;

  typedef enum logic [1:0] {
    WK_EDGE_UP  = 2'd0,
    WK_EDGE_DN  = 2'd1,
    WK_EMPTY_DN = 2'd2,
    WK_EMPTY_UP = 2'd3
  } walk_e;

  state_e state_q, state_d;
  walk_e  walk_q, walk_d;
  logic   walk_down, walk_cond, walk_bound;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      walk_q  <= WK_EDGE_UP;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
    end
  end

  assign walk_down  = (walk_q == WK_EDGE_DN) || (walk_q == WK_EMPTY_DN);
  assign walk_cond  = ((walk_q == WK_EDGE_UP) || (walk_q == WK_EDGE_DN)) ?
                      sts_i.ent_edge : sts_i.ent_count_zero;
  assign walk_bound = walk_down ? sts_i.tmp_min : sts_i.tmp_max;

  always_comb begin
    state_d    = state_q;
    walk_d     = walk_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mode = MODE_OOB;
    cmd_o.base = B_KEEP;
    cmd_o.lohi = LH_KEEP;
    cmd_o.off  = OFF_ZERO;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = ~sts_i.clr_done;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (req_type_i)
            REQ_PREFIX: cmd_o.pt_wr = 1'b1;
            REQ_SUFFIX: cmd_o.st_wr = 1'b1;
            REQ_LOOKUP: begin
              cmd_o.lat_req = 1'b1;
              state_d       = S_K_RD;
            end
            default: ;
          endcase
        end
      end
      S_K_RD: begin
        cmd_o.pt_rd_key    = 1'b1;
        cmd_o.tmp_load_key = 1'b1;
        state_d            = S_K_CHK;
      end
      S_K_CHK: begin
        cmd_o.set_mode = 1'b1;
        cmd_o.n_load   = 1'b1;
        cmd_o.base     = B_FIRST;
        cmd_o.lohi     = LH_ZERO_ONE;
        if (sts_i.ent_edge) begin
          cmd_o.mode = MODE_OOB;
          walk_d     = sts_i.ent_first_zero ? WK_EDGE_UP : WK_EDGE_DN;
          state_d    = S_W_CHK;
        end else if (sts_i.ent_count_zero) begin
          cmd_o.mode = MODE_EMPTY;
          walk_d     = WK_EMPTY_DN;
          state_d    = S_W_CHK;
        end else begin
          cmd_o.mode    = MODE_SEARCH;
          cmd_o.lp_load = 1'b1;
          cmd_o.up_load = 1'b1;
          state_d       = S_RD0;
        end
      end
      S_W_RD: begin
        cmd_o.pt_rd_tmp = 1'b1;
        state_d         = S_W_CHK;
      end
      S_W_CHK: begin
        if (walk_cond && !walk_bound) begin
          cmd_o.tmp_dec = walk_down;
          cmd_o.tmp_inc = ~walk_down;
          state_d       = S_W_RD;
        end else begin
          case (walk_q)
            WK_EDGE_UP: begin
              cmd_o.lp_load = 1'b1;
              cmd_o.up_load = 1'b1;
              cmd_o.base    = B_ZERO;
              cmd_o.lohi    = LH_ZERO;
              state_d       = S_F_RLO;
            end
            WK_EDGE_DN: begin
              cmd_o.lp_load = 1'b1;
              cmd_o.up_load = 1'b1;
              cmd_o.base    = B_LAST;
              cmd_o.lohi    = LH_ZERO;
              state_d       = S_F_RLO;
            end
            WK_EMPTY_DN: begin
              cmd_o.lp_load      = 1'b1;
              cmd_o.tmp_load_key = 1'b1;
              walk_d             = WK_EMPTY_UP;
              state_d            = S_W_RD;
            end
            default: begin
              cmd_o.up_load = 1'b1;
              state_d       = S_F_RLO;
            end
          endcase
        end
      end
      S_RD0: begin
        cmd_o.st_rd = 1'b1;
        cmd_o.off   = OFF_ZERO;
        state_d     = S_CK0;
      end
      S_CK0: begin
        if (sts_i.s_lt) begin
          cmd_o.lohi = LH_ZERO;
          state_d    = S_F_RLO;
        end else begin
          state_d = S_RDN;
        end
      end
      S_RDN: begin
        cmd_o.st_rd = 1'b1;
        cmd_o.off   = OFF_LAST;
        state_d     = S_CKN;
      end
      S_CKN: begin
        if (sts_i.s_gt) begin
          cmd_o.lohi = LH_LAST;
          state_d    = S_F_RLO;
        end else begin
          cmd_o.lohi = LH_FULL;
          state_d    = S_L_CK;
        end
      end
      S_L_CK: begin
        if (sts_i.span_gt1) begin
          cmd_o.st_rd = 1'b1;
          cmd_o.off   = OFF_MID;
          state_d     = S_L_CMP;
        end else begin
          state_d = S_F_RLO;
        end
      end
      S_L_CMP: begin
        if (sts_i.s_eq) begin
          cmd_o.lo_mid = 1'b1;
          state_d      = S_F_RLO;
        end else if (sts_i.s_gt) begin
          cmd_o.lo_mid = 1'b1;
          state_d      = S_L_CK;
        end else begin
          cmd_o.hi_mid = 1'b1;
          state_d      = S_L_CK;
        end
      end
      S_F_RLO: begin
        cmd_o.st_rd = 1'b1;
        cmd_o.off   = OFF_LO;
        state_d     = S_F_RHI;
      end
      S_F_RHI: begin
        cmd_o.lat_lower = 1'b1;
        cmd_o.st_rd     = 1'b1;
        cmd_o.off       = OFF_HI;
        state_d         = S_F_HI;
      end
      S_F_HI: begin
        cmd_o.lat_upper = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> hdl/psnl_dp.sv
// Datapath: prefix table and suffix store memories, walk pointer, search bounds, result register
module psnl_dp #(
  parameter int PREFIX_COUNT = psnl_pkg::DEF_PREFIX_COUNT,
  parameter int SUFFIX_DEPTH = psnl_pkg::DEF_SUFFIX_DEPTH,
  parameter int SUFFIX_WIDTH = psnl_pkg::DEF_SUFFIX_WIDTH,
  parameter int CLASS_WIDTH  = psnl_pkg::DEF_CLASS_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  psnl_pkg::dp_cmd_t              cmd_i,
  output psnl_pkg::dp_sts_t              sts_o,
  input  logic [psnl_pkg::KEY_W-1:0]     prefix_key_i,
  input  logic [psnl_pkg::FIRST_W-1:0]   entry_first_i,
  input  logic [psnl_pkg::CNT_W-1:0]     entry_count_i,
  input  logic                           entry_edge_i,
  input  logic [psnl_pkg::SIDX_W-1:0]    suffix_index_i,
  input  logic [SUFFIX_WIDTH-1:0]        suffix_value_i,
  input  logic [CLASS_WIDTH-1:0]         class_value_i,
  input  logic [SUFFIX_WIDTH-1:0]        search_suffix_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [psnl_pkg::STAT_W-1:0]    status_o,
  output logic [psnl_pkg::KEY_W-1:0]     below_prefix_o,
  output logic [SUFFIX_WIDTH-1:0]        below_suffix_o,
  output logic [CLASS_WIDTH-1:0]         below_class_o,
  output logic [psnl_pkg::KEY_W-1:0]     above_prefix_o,
  output logic [SUFFIX_WIDTH-1:0]        above_suffix_o,
  output logic [CLASS_WIDTH-1:0]         above_class_o
);
  import psnl_pkg::*;

  // depths are powers of two: keys and store addresses wrap by truncation
  localparam int PAW  = $clog2(PREFIX_COUNT);
  localparam int SAW  = $clog2(SUFFIX_DEPTH);
  localparam int SUMW = ((SAW > CNT_W) ? SAW : CNT_W) + 1;
  localparam logic [PAW-1:0] PMAX = PAW'(PREFIX_COUNT - 1);

  pt_ent_t                  pt_mem [PREFIX_COUNT];
  logic [SUFFIX_WIDTH-1:0]  suf_mem [SUFFIX_DEPTH];
  logic [CLASS_WIDTH-1:0]   cls_mem [SUFFIX_DEPTH];

  pt_ent_t                  pt_rdata_q, pt_wdata;
  logic                     pt_we;
  logic [PAW-1:0]           pt_waddr, pt_raddr;
  logic [PAW-1:0]           clr_q;
  logic                     clr_done_q;
  logic [PAW-1:0]           key_q, tmp_q, lp_q, up_q;
  logic [SUFFIX_WIDTH-1:0]  search_q, rd_suf_q, lo_suf_q, hi_suf_q;
  logic [CLASS_WIDTH-1:0]   rd_cls_q, lo_cls_q, hi_cls_q;
  logic [SAW-1:0]           base_q, st_raddr;
  logic [CNT_W-1:0]         n_q, lo_q, hi_q, mid, off;
  logic [CNT_W:0]           span_sum;
  mode_e                    mode_q;
  status_e                  stat_q;
  logic                     out_valid_q;
  status_e                  out_stat_q;
  logic [PAW-1:0]           out_lp_q, out_up_q;
  logic [SUFFIX_WIDTH-1:0]  out_lsuf_q, out_usuf_q;
  logic [CLASS_WIDTH-1:0]   out_lcls_q, out_ucls_q;

  // prefix table: one write port shared by the clear sweep, one registered read
  assign pt_we    = cmd_i.pt_wr | cmd_i.clr_wr;
  assign pt_waddr = cmd_i.clr_wr ? clr_q : PAW'(prefix_key_i);
  assign pt_raddr = cmd_i.pt_rd_key ? key_q : tmp_q;
  always_comb begin
    pt_wdata = '0;
    if (!cmd_i.clr_wr) begin
      pt_wdata.first     = entry_first_i;
      pt_wdata.count     = entry_count_i;
      pt_wdata.edge_flag = entry_edge_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    if (cmd_i.pt_rd_key || cmd_i.pt_rd_tmp) pt_rdata_q <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_done_q <= 1'b0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == PMAX) clr_done_q <= 1'b1;
    end
  end

  // suffix store offset select and wrapped address
  assign span_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = span_sum[CNT_W:1];
  always_comb begin
    case (cmd_i.off)
      OFF_ZERO: off = '0;
      OFF_LAST: off = n_q - 1'b1;
      OFF_MID:  off = mid;
      OFF_LO:   off = lo_q;
      OFF_HI:   off = hi_q;
      default:  off = '0;
    endcase
  end
  assign st_raddr = SAW'(SUMW'(base_q) + SUMW'(off));

  always_ff @(posedge clk_i) begin
    if (cmd_i.st_wr) begin
      suf_mem[SAW'(suffix_index_i)] <= suffix_value_i;
      cls_mem[SAW'(suffix_index_i)] <= class_value_i;
    end
    if (cmd_i.st_rd) begin
      rd_suf_q <= suf_mem[st_raddr];
      rd_cls_q <= cls_mem[st_raddr];
    end
  end

  // lookup registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_req) begin
      key_q    <= PAW'(prefix_key_i);
      search_q <= search_suffix_i;
    end
    if (cmd_i.tmp_load_key)  tmp_q <= key_q;
    else if (cmd_i.tmp_inc)  tmp_q <= tmp_q + 1'b1;
    else if (cmd_i.tmp_dec)  tmp_q <= tmp_q - 1'b1;
    if (cmd_i.lp_load) lp_q <= tmp_q;
    if (cmd_i.up_load) up_q <= tmp_q;
    if (cmd_i.set_mode) mode_q <= cmd_i.mode;
    if (cmd_i.n_load) n_q <= pt_rdata_q.count;
    case (cmd_i.base)
      B_ZERO:  base_q <= '0;
      B_FIRST: base_q <= SAW'(pt_rdata_q.first);
      B_LAST:  base_q <= SAW'(SUMW'(pt_rdata_q.first) + SUMW'(pt_rdata_q.count) - SUMW'(1));
      default: ;
    endcase
    case (cmd_i.lohi)
      LH_ZERO: begin
        lo_q <= '0;
        hi_q <= '0;
      end
      LH_ZERO_ONE: begin
        lo_q <= '0;
        hi_q <= CNT_W'(1);
      end
      LH_LAST: begin
        lo_q <= n_q - 1'b1;
        hi_q <= n_q - 1'b1;
      end
      LH_FULL: begin
        lo_q <= '0;
        hi_q <= n_q - 1'b1;
      end
      default: begin
        if (cmd_i.lo_mid) lo_q <= mid;
        if (cmd_i.hi_mid) hi_q <= mid;
      end
    endcase
    if (cmd_i.lat_lower) begin
      lo_suf_q <= rd_suf_q;
      lo_cls_q <= rd_cls_q;
    end
    // in search mode, a suffix match at either bound collapses both neighbors onto it
    if (cmd_i.lat_upper) begin
      hi_suf_q <= rd_suf_q;
      hi_cls_q <= rd_cls_q;
      stat_q   <= (mode_q == MODE_OOB) ? ST_OOB : ST_INEXACT;
      if (mode_q == MODE_SEARCH) begin
        if (lo_suf_q == search_q) begin
          hi_suf_q <= lo_suf_q;
          hi_cls_q <= lo_cls_q;
          stat_q   <= ST_EXACT;
        end else if (rd_suf_q == search_q) begin
          lo_suf_q <= rd_suf_q;
          lo_cls_q <= rd_cls_q;
          stat_q   <= ST_EXACT;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= cmd_i.out_load | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_stat_q <= stat_q;
      out_lp_q   <= lp_q;
      out_up_q   <= up_q;
      out_lsuf_q <= lo_suf_q;
      out_lcls_q <= lo_cls_q;
      out_usuf_q <= hi_suf_q;
      out_ucls_q <= hi_cls_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_stat_q;
  assign below_prefix_o = KEY_W'(out_lp_q);
  assign above_prefix_o = KEY_W'(out_up_q);
  assign below_suffix_o = out_lsuf_q;
  assign below_class_o  = out_lcls_q;
  assign above_suffix_o = out_usuf_q;
  assign above_class_o  = out_ucls_q;

  assign sts_o.clr_done       = clr_done_q;
  assign sts_o.ent_edge       = pt_rdata_q.edge_flag;
  assign sts_o.ent_first_zero = (pt_rdata_q.first == '0);
  assign sts_o.ent_count_zero = (pt_rdata_q.count == '0);
  assign sts_o.tmp_min        = (tmp_q == '0);
  assign sts_o.tmp_max        = (tmp_q == PMAX);
  assign sts_o.s_lt           = (search_q < rd_suf_q);
  assign sts_o.s_gt           = (search_q > rd_suf_q);
  assign sts_o.s_eq           = (search_q == rd_suf_q);
  assign sts_o.span_gt1       = ({1'b0, hi_q} > ({1'b0, lo_q} + 1'b1));
  assign sts_o.out_busy       = out_valid_q & ~out_ready_i;

endmodule
